// ===== rtl/bbc_pkg.sv =====
// Package for the byte budget object cache: sizes, status and pass codes,
// the word that travels along the cell chain, and a saturating subtract.
// No dependencies.
package bbc_pkg;

	localparam int ENTRY_COUNT = 16;
	localparam int IDX_W       = $clog2(ENTRY_COUNT);
	localparam int KEY_W       = 64;
	localparam int BYTES_W     = 32;
	localparam int STATUS_W    = 2;
	localparam int SLOT_W      = 4;
	localparam int MASK_W      = 16;

	localparam logic [BYTES_W-1:0] LIMIT_RESET = 32'd1048576;

	localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INSERT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

	// pass carried by a token along the chain
	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_EVICT  = 2'd1;
	localparam logic [1:0] MODE_FIX    = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [KEY_W-1:0]   key;
		logic [BYTES_W-1:0] bytes;
		logic               found;
		logic [IDX_W-1:0]   hit_slot;
		logic [BYTES_W-1:0] total;
		logic [MASK_W-1:0]  mask;
		logic               free_found;
		logic [IDX_W-1:0]   free_slot;
		logic [BYTES_W-1:0] first_bytes;
	} carry_t;

	typedef struct packed {
		logic   tok;
		carry_t c;
	} link_t;

	function automatic logic [BYTES_W-1:0] sat_sub(input logic [BYTES_W-1:0] a,
		input logic [BYTES_W-1:0] b);
		sat_sub = (b > a) ? '0 : a - b;
	endfunction

endpackage

// ===== rtl/bbc_cell.sv =====
// One cache slot of the cell chain: holds valid, key and size of one entry
// and handles a passing token for lookup, eviction/insert or slot-0 reuse.
// Depends on bbc_pkg.
module bbc_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bbc_pkg::IDX_W-1:0]     idx,
	input  logic [bbc_pkg::BYTES_W-1:0]   limit,
	input  bbc_pkg::link_t                link_in,
	output bbc_pkg::link_t                link_out
);

	logic                          valid_q;
	logic [bbc_pkg::KEY_W-1:0]     key_q;
	logic [bbc_pkg::BYTES_W-1:0]   bytes_q;
	logic                          tok_q;
	bbc_pkg::carry_t               c_q;
	bbc_pkg::carry_t               c_next;
	logic                          over;
	logic                          ev;
	logic                          post_valid;
	logic                          wr;
	logic                          clr;
	logic                          fwd;

	assign over = ({1'b0, link_in.c.total} + {1'b0, link_in.c.bytes}) > {1'b0, limit};

	always_comb begin
		c_next     = link_in.c;
		ev         = 1'b0;
		post_valid = valid_q;
		wr         = 1'b0;
		clr        = 1'b0;
		fwd        = link_in.tok;
		case (link_in.c.mode)
			bbc_pkg::MODE_LOOKUP: begin
				if (!link_in.c.found && valid_q && key_q == link_in.c.key) begin
					c_next.found    = 1'b1;
					c_next.hit_slot = idx;
				end
			end
			bbc_pkg::MODE_EVICT: begin
				ev         = valid_q && over;
				post_valid = valid_q && !ev;
				if (ev) begin
					clr          = 1'b1;
					c_next.total = bbc_pkg::sat_sub(link_in.c.total, bytes_q);
					c_next.mask  = link_in.c.mask |
						(bbc_pkg::MASK_W'(1) << idx);
				end
				// first slot still free once its own eviction is settled
				if (!link_in.c.free_found && !post_valid) begin
					wr                = 1'b1;
					c_next.free_found = 1'b1;
					c_next.free_slot  = idx;
				end
				if (idx == '0) begin
					c_next.first_bytes = bytes_q;
				end
			end
			bbc_pkg::MODE_FIX: begin
				// reuse slot 0 when every slot is held; drop the token here
				wr  = (idx == '0);
				fwd = 1'b0;
			end
			default: begin
				fwd = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= fwd;
			if (link_in.tok && wr) begin
				valid_q <= 1'b1;
			end else if (link_in.tok && clr) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.tok) begin
			c_q <= c_next;
		end
		if (link_in.tok && wr) begin
			key_q   <= link_in.c.key;
			bytes_q <= link_in.c.bytes;
		end
	end

	assign link_out.tok = tok_q;
	assign link_out.c   = c_q;

endmodule

// ===== rtl/bbc_ctrl.sv =====
// Sequencer of the object cache: takes requests and the limit register,
// launches tokens into the cell chain and turns returning tokens into results.
// Depends on bbc_pkg.
module bbc_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [bbc_pkg::KEY_W-1:0]       object_key,
	input  logic [bbc_pkg::BYTES_W-1:0]     object_bytes,
	input  logic                            cfg_we,
	input  logic [bbc_pkg::BYTES_W-1:0]     cfg_wdata,
	output logic [bbc_pkg::BYTES_W-1:0]     limit,
	output bbc_pkg::link_t                  launch,
	input  bbc_pkg::link_t                  chain_end,
	output logic                            done,
	output logic [bbc_pkg::STATUS_W-1:0]    status,
	output logic [bbc_pkg::SLOT_W-1:0]      slot,
	output logic [bbc_pkg::MASK_W-1:0]      evicted_mask,
	output logic [bbc_pkg::BYTES_W-1:0]     used_bytes
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_LOOK  = 2'd1;
	localparam logic [1:0] S_EVICT = 2'd2;

	logic [1:0]                     state_q;
	logic [bbc_pkg::BYTES_W-1:0]    limit_q;
	logic [bbc_pkg::BYTES_W-1:0]    total_q;
	logic                           launch_tok_q;
	bbc_pkg::carry_t                launch_c_q;
	logic                           done_q;
	logic [bbc_pkg::STATUS_W-1:0]   status_q;
	logic [bbc_pkg::SLOT_W-1:0]     slot_q;
	logic [bbc_pkg::MASK_W-1:0]     mask_q;
	logic [bbc_pkg::BYTES_W-1:0]    used_q;
	logic                           look_end;
	logic                           evict_end;
	logic [bbc_pkg::BYTES_W-1:0]    reuse_base;

	assign look_end   = (state_q == S_LOOK) && chain_end.tok &&
		(chain_end.c.mode == bbc_pkg::MODE_LOOKUP);
	assign evict_end  = (state_q == S_EVICT) && chain_end.tok &&
		(chain_end.c.mode == bbc_pkg::MODE_EVICT);
	assign reuse_base = bbc_pkg::sat_sub(chain_end.c.total, chain_end.c.first_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			limit_q      <= bbc_pkg::LIMIT_RESET;
			total_q      <= '0;
			launch_tok_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			launch_tok_q <= 1'b0;
			done_q       <= 1'b0;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						launch_tok_q <= 1'b1;
						state_q      <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (look_end) begin
						if (chain_end.c.found || chain_end.c.bytes > limit_q) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							launch_tok_q <= 1'b1;
							state_q      <= S_EVICT;
						end
					end
				end
				S_EVICT: begin
					if (evict_end) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (chain_end.c.free_found) begin
							total_q <= chain_end.c.total + chain_end.c.bytes;
						end else begin
							launch_tok_q <= 1'b1;
							total_q      <= reuse_base + chain_end.c.bytes;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					launch_c_q            <= '0;
					launch_c_q.mode       <= bbc_pkg::MODE_LOOKUP;
					launch_c_q.key        <= object_key;
					launch_c_q.bytes      <= object_bytes;
				end
			end
			S_LOOK: begin
				if (look_end) begin
					launch_c_q       <= chain_end.c;
					launch_c_q.mode  <= bbc_pkg::MODE_EVICT;
					launch_c_q.total <= total_q;
					launch_c_q.mask  <= '0;
					mask_q           <= '0;
					used_q           <= total_q;
					if (chain_end.c.found) begin
						status_q <= bbc_pkg::ST_HIT;
						slot_q   <= bbc_pkg::SLOT_W'(chain_end.c.hit_slot);
					end else begin
						status_q <= bbc_pkg::ST_REJECT;
						slot_q   <= '0;
					end
				end
			end
			S_EVICT: begin
				if (evict_end) begin
					status_q        <= bbc_pkg::ST_INSERT;
					launch_c_q      <= chain_end.c;
					launch_c_q.mode <= bbc_pkg::MODE_FIX;
					if (chain_end.c.free_found) begin
						slot_q <= bbc_pkg::SLOT_W'(chain_end.c.free_slot);
						mask_q <= chain_end.c.mask;
						used_q <= chain_end.c.total + chain_end.c.bytes;
					end else begin
						slot_q <= '0;
						mask_q <= chain_end.c.mask | bbc_pkg::MASK_W'(1);
						used_q <= reuse_base + chain_end.c.bytes;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign limit        = limit_q;
	assign launch.tok   = launch_tok_q;
	assign launch.c     = launch_c_q;
	assign done         = done_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign evicted_mask = mask_q;
	assign used_bytes   = used_q;

endmodule

// ===== rtl/byte_budget_object_cache.sv =====
// Top level of the byte budget object cache: sequencer plus a chain of
// slot cells. Depends on bbc_pkg, bbc_ctrl and bbc_cell.
//
// Usage:
//   Request: drive object_key and object_bytes with start high; the word is
//   taken at a rising edge where start is high and busy is low. busy stays
//   high until the result is out.
//   Result: done is high for exactly one cycle with status, slot,
//   evicted_mask and used_bytes valid in that cycle. The receiver cannot
//   stall; capture the word when done is seen. busy is low in the done
//   cycle, so a new request may be taken there.
//   Config: cfg_we with cfg_wdata writes byte_limit at the clock edge; write
//   it only while busy is low and no result is pending.
//   Passes: a token walks the slot chain one cell per cycle. A hit or reject
//   is done after the lookup pass. A miss that is inserted runs a second
//   eviction/insert pass before done. When every slot is held after
//   eviction, slot 0 is rewritten at the edge that ends the done cycle.
//   Flow: one request in flight; a new request is taken only once the
//   result of the last one is out.
//   Reset: arst_n clears all valid bits, the held-byte total and the limit
//   back to 1 MiB at once; no clearing pass is needed.
module byte_budget_object_cache (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [bbc_pkg::KEY_W-1:0]       object_key,
	input  logic [bbc_pkg::BYTES_W-1:0]     object_bytes,
	input  logic                            cfg_we,
	input  logic [bbc_pkg::BYTES_W-1:0]     cfg_wdata,
	output logic                            done,
	output logic [bbc_pkg::STATUS_W-1:0]    status,
	output logic [bbc_pkg::SLOT_W-1:0]      slot,
	output logic [bbc_pkg::MASK_W-1:0]      evicted_mask,
	output logic [bbc_pkg::BYTES_W-1:0]     used_bytes
);

	// links[i] feeds cell i; links[ENTRY_COUNT] returns to the sequencer
	bbc_pkg::link_t                 links [bbc_pkg::ENTRY_COUNT+1];
	logic [bbc_pkg::BYTES_W-1:0]    limit;

	bbc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.object_key   (object_key),
		.object_bytes (object_bytes),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.limit        (limit),
		.launch       (links[0]),
		.chain_end    (links[bbc_pkg::ENTRY_COUNT]),
		.done         (done),
		.status       (status),
		.slot         (slot),
		.evicted_mask (evicted_mask),
		.used_bytes   (used_bytes)
	);

	// Advance each token one slot per cycle; cell i registers its updated
	// word and hands it to cell i+1.
	for (genvar i = 0; i < bbc_pkg::ENTRY_COUNT; i++) begin : g_cell
		bbc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (bbc_pkg::IDX_W'(i)),
			.limit    (limit),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

endmodule

// ===== rtl/bbc_checker.sv =====
// Port-level checks for the byte budget object cache, bound to the top level.
// Depends on bbc_pkg and byte_budget_object_cache.
module bbc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic [bbc_pkg::STATUS_W-1:0]    status,
	input logic [bbc_pkg::SLOT_W-1:0]      slot,
	input logic [bbc_pkg::MASK_W-1:0]      evicted_mask
);

	// raise busy once a request word is taken
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request accept");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == bbc_pkg::ST_HIT || status == bbc_pkg::ST_INSERT ||
			status == bbc_pkg::ST_REJECT))
		else $error("undefined status code");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == bbc_pkg::ST_REJECT) |-> (slot == '0 && evicted_mask == '0))
		else $error("rejected request reports slot or evictions");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == bbc_pkg::ST_HIT) |-> (evicted_mask == '0))
		else $error("hit reports evictions");

endmodule

bind byte_budget_object_cache bbc_checker u_bbc_checker (.*);

// ===== sim/tb.sv =====
// Self-checking bench for byte_budget_object_cache: a clocked driver issues queued
// lookups and byte_limit writes, and a clocked monitor checks each result word.
// Depends on bbc_pkg and the byte_budget_object_cache RTL.
`timescale 1ns / 100ps

module tb;
	import bbc_pkg::*;

	localparam int TB_CLK_HALF   = 2;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 3;   // quiet cycles ahead of a byte_limit write
	localparam int QUIET_FROM    = 400; // request counts bounding the gap-free stretch
	localparam int QUIET_TO      = 520;
	localparam int PHASE_ITEMS   = 120;
	localparam int POOL_SIZE     = 32;

	typedef enum logic [1:0] {
		ITEM_REQ,
		ITEM_CFG,
		ITEM_DRAIN
	} item_kind_e;

	typedef struct {
		item_kind_e         kind;
		logic [KEY_W-1:0]   key;
		logic [BYTES_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [MASK_W-1:0]   mask;
		logic [BYTES_W-1:0]  used;
	} outcome_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic [KEY_W-1:0]   object_key   = '0;
	logic [BYTES_W-1:0] object_bytes = '0;
	logic               cfg_we       = 1'b0;
	logic [BYTES_W-1:0] cfg_wdata    = '0;
	logic               busy;
	logic               done;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [MASK_W-1:0]   evicted_mask;
	logic [BYTES_W-1:0]  used_bytes;

	byte_budget_object_cache dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.object_key   (object_key),
		.object_bytes (object_bytes),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.status       (status),
		.slot         (slot),
		.evicted_mask (evicted_mask),
		.used_bytes   (used_bytes)
	);

	// Shadow copy of the cache contents and the byte budget.
	logic               held       [ENTRY_COUNT] = '{default: 1'b0};
	logic [KEY_W-1:0]   held_key   [ENTRY_COUNT];
	logic [BYTES_W-1:0] held_bytes [ENTRY_COUNT];
	logic [BYTES_W-1:0] held_total = '0;
	logic [BYTES_W-1:0] limit_q    = LIMIT_RESET;

	item_t    queued_words[$];
	outcome_t predicted_results[$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	int sent_count     = 0;
	int settle_count   = 0;
	int hold_off       = 0;
	int limit_writes   = 0;
	int mismatch_count = 0;
	int hit_count      = 0;
	int insert_count   = 0;
	int reject_count   = 0;

	initial begin
		forever #(TB_CLK_HALF) clk = ~clk;
	end

	// Drop one held object: clear its valid bit, give back its bytes (never
	// below zero) and mark it in the eviction mask.
	function automatic void drop_entry(input int idx, inout logic [MASK_W-1:0] mask);
		held[idx] = 1'b0;
		held_total = (held_bytes[idx] > held_total) ? '0 : held_total - held_bytes[idx];
		if (idx < MASK_W)
			mask[idx] = 1'b1;
	endfunction

	// Look the key up; on a miss either reject an oversized object or evict
	// from slot 0 upward until it fits, then write the lowest free slot (slot 0 if none).
	function automatic outcome_t serve_request(input logic [KEY_W-1:0] key,
		input logic [BYTES_W-1:0] size);
		outcome_t r;
		int       i;
		int       w;
		logic     hit;
		logic     have_free;
		r = '0;
		hit = 1'b0;
		have_free = 1'b0;
		w = 0;
		for (i = 0; i < ENTRY_COUNT; i++) begin
			if (!hit && held[i] && held_key[i] == key) begin
				hit = 1'b1;
				r.slot = SLOT_W'(i);
			end
		end
		if (hit) begin
			r.status = ST_HIT;
		end else if (size > limit_q) begin
			r.status = ST_REJECT;
		end else begin
			// 33-bit sum so a large total plus size cannot wrap
			for (i = 0; i < ENTRY_COUNT; i++) begin
				if ({1'b0, held_total} + {1'b0, size} > {1'b0, limit_q} && held[i])
					drop_entry(i, r.mask);
			end
			for (i = 0; i < ENTRY_COUNT; i++) begin
				if (!have_free && !held[i]) begin
					have_free = 1'b1;
					w = i;
				end
			end
			// every slot still taken: reuse slot 0
			if (!have_free) begin
				w = 0;
				drop_entry(0, r.mask);
			end
			held[w] = 1'b1;
			held_key[w] = key;
			held_bytes[w] = size;
			held_total = held_total + size;
			r.slot = SLOT_W'(w);
			r.status = ST_INSERT;
		end
		r.used = held_total;
		return r;
	endfunction

	function automatic void add_request(input logic [KEY_W-1:0] k, input logic [BYTES_W-1:0] b);
		queued_words.push_back('{ITEM_REQ, k, b});
	endfunction

	function automatic void add_limit(input logic [BYTES_W-1:0] v);
		queued_words.push_back('{ITEM_CFG, '0, v});
	endfunction

	task automatic check_field(input string name, input logic [BYTES_W-1:0] want,
		input logic [BYTES_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Driver: sample the handshake before the edge updates, predict each
	// accepted word, then drive the next request or register write.
	always @(posedge clk) begin : drive_words
		item_t              head;
		logic               taken;
		logic               n_start;
		logic               n_we;
		logic [KEY_W-1:0]   n_key;
		logic [BYTES_W-1:0] n_bytes;
		logic [BYTES_W-1:0] n_wdata;
		if (arst_n) begin
			taken = start && !busy;
			n_start = start && !taken;
			n_key = object_key;
			n_bytes = object_bytes;
			n_we = 1'b0;
			n_wdata = cfg_wdata;
			if (taken) begin
				predicted_results.push_back(serve_request(object_key, object_bytes));
				sent_count++;
			end
			// count cycles with nothing in flight; a done this edge still pops
			if (predicted_results.size() == 0 && !busy && !done && !start)
				settle_count++;
			else
				settle_count = 0;
			if (!n_start && queued_words.size() != 0) begin
				head = queued_words[0];
				case (head.kind)
					ITEM_REQ: begin
						if (hold_off > 0) begin
							hold_off--;
						end else begin
							void'(queued_words.pop_front());
							n_start = 1'b1;
							n_key = head.key;
							n_bytes = head.value;
							// pick the gap before the following word; long gaps land the
							// next start anywhere in the lookup and eviction passes
							if (sent_count >= QUIET_FROM && sent_count < QUIET_TO)
								hold_off = 0;
							else if ($urandom_range(0, 99) < 18)
								hold_off = $urandom_range(1, 45);
							else
								hold_off = 0;
						end
					end
					ITEM_CFG: begin
						// write the limit only once the cache has gone quiet
						if (settle_count >= SETTLE_CYCLES) begin
							void'(queued_words.pop_front());
							n_we = 1'b1;
							n_wdata = head.value;
							limit_q = head.value;
							limit_writes++;
						end
					end
					ITEM_DRAIN: begin
						// hold off the sender until every result is back
						if (settle_count >= 1)
							void'(queued_words.pop_front());
					end
					default: begin
						void'(queued_words.pop_front());
					end
				endcase
			end
			start <= n_start;
			object_key <= n_key;
			object_bytes <= n_bytes;
			cfg_we <= n_we;
			cfg_wdata <= n_wdata;
		end
	end

	// Monitor: a result word lives for one cycle only; take it on done.
	always @(posedge clk) begin : watch_results
		outcome_t want;
		if (arst_n && done) begin
			if (predicted_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d slot %0d",
					$time, status, slot);
				mismatch_count++;
			end else begin
				want = predicted_results.pop_front();
				check_field("status", BYTES_W'(want.status), BYTES_W'(status));
				check_field("slot", BYTES_W'(want.slot), BYTES_W'(slot));
				check_field("evicted_mask", BYTES_W'(want.mask), BYTES_W'(evicted_mask));
				check_field("used_bytes", want.used, used_bytes);
			end
			case (status)
				ST_HIT:    hit_count++;
				ST_INSERT: insert_count++;
				default:   reject_count++;
			endcase
		end
	end

	initial begin : run_test
		logic [BYTES_W-1:0] phase_limit [7];
		logic [BYTES_W-1:0] lim;
		logic [BYTES_W-1:0] b;
		logic [KEY_W-1:0]   k;
		int                 p;
		int                 n;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (n = 2; n < POOL_SIZE; n++)
			key_pool[n] = {$urandom, $urandom};

		// Directed: hit, exact-limit fit, oversized rejects, size ignored on a
		// hit, eviction from slot 0 upward, limit lowered below the held total.
		add_request('0, '0);
		add_request('0, '0);
		add_request('1, LIMIT_RESET);
		add_request(64'd5, LIMIT_RESET + 1);
		add_request(64'd6, '1);
		add_request('1, '0);
		add_request(64'd7, 32'd1);
		add_limit('0);
		add_request(64'd7, '0);
		add_request(64'd8, '0);
		add_request(64'd9, 32'd1);
		// fill the free slots; the last key finds none and reuses slot 0, then hits
		for (n = 0; n < ENTRY_COUNT; n++)
			add_request(64'd100 + n, '0);
		add_request(64'd100 + ENTRY_COUNT - 1, '0);

		// Random phases, each under its own byte budget.
		phase_limit[0] = 32'd64;
		phase_limit[1] = '0;
		phase_limit[2] = '1;
		phase_limit[3] = $urandom;
		phase_limit[4] = 32'd1;
		phase_limit[5] = 32'd5000;
		phase_limit[6] = LIMIT_RESET;
		for (p = 0; p < 7; p++) begin
			lim = phase_limit[p];
			add_limit(lim);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == PHASE_ITEMS / 2)
					queued_words.push_back('{ITEM_DRAIN, '0, '0});
				// mostly reuse pooled keys so hits and re-inserts happen
				if ($urandom_range(0, 9) < 7)
					k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					k = {$urandom, $urandom};
				case ($urandom_range(0, 19))
					0:       b = '0;
					1:       b = lim;
					2:       b = (lim == '1) ? lim : lim + 1;
					3:       b = '1;
					4, 5:    b = $urandom;
					default: b = $urandom_range(0, ($urandom_range(0, 1) == 1) ? lim >> 2 : lim >> 5);
				endcase
				add_request(k, b);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// sample on the falling edge so the driver's updates have settled
		do
			@(negedge clk);
		while (queued_words.size() != 0 || predicted_results.size() != 0 || start || busy);
		repeat (2 * ENTRY_COUNT + 8) @(posedge clk);

		if (predicted_results.size() != 0) begin
			$display("%0t: %0d results never arrived, expected 0 outstanding",
				$time, predicted_results.size());
			mismatch_count++;
		end
		$display("Covered %0d requests: %0d hits, %0d inserts, %0d rejects, %0d limit writes",
			sent_count, hit_count, insert_count, reject_count, limit_writes);
		if (mismatch_count == 0) begin
			$display("PASS byte_budget_object_cache");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("FAIL byte_budget_object_cache");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Timed out with %0d results outstanding", predicted_results.size());
		$display("FAIL byte_budget_object_cache");
		$finish;
	end

endmodule
